// File: design/ultl_pkg.sv
package ultl_pkg;

  // Widths fixed by the register and field definitions.
  localparam int unsigned MIN_WIDTH = 11;
  localparam int unsigned CFG_WIDTH = 11;
  localparam int unsigned CFG_IDX_WIDTH = 1;

  localparam int unsigned SECONDS_PER_MINUTE_DEF = 60;
  localparam int unsigned COUNT_WIDTH_DEF = 17;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_WARN = 1'b0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_MAX = 1'b1;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_REST_DONE = 2'd1,
    CMD_PARENT    = 2'd2,
    CMD_SUSPEND   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    LK_NONE = 2'd0,
    LK_REST = 2'd1,
    LK_UNAV = 2'd2
  } lock_e;

  typedef struct packed {
    lock_e lock_state;
    logic  show_warning;
    logic  start_rest_lock;
    logic  start_unavailable_lock;
  } result_t;

endpackage

// File: design/ultl_to_secs.sv
module ultl_to_secs
  import ultl_pkg::*;
#(
  parameter int unsigned SECONDS_PER_MINUTE = SECONDS_PER_MINUTE_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic [MIN_WIDTH-1:0]   minutes_i,
  output logic [COUNT_WIDTH-1:0] secs_o
);

  localparam int unsigned ProdW = MIN_WIDTH + $clog2(SECONDS_PER_MINUTE + 1);
  localparam int unsigned SumW = (ProdW > COUNT_WIDTH) ? ProdW : COUNT_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] CntMax = {COUNT_WIDTH{1'b1}};

  logic [SumW-1:0] prod;

  // Minutes times a small constant, clamped to the counter range.
  assign prod = SumW'(minutes_i) * SumW'(SECONDS_PER_MINUTE);
  assign secs_o = (prod > SumW'(CntMax)) ? CntMax : COUNT_WIDTH'(prod);

endmodule

// File: design/ultl_cfg.sv
module ultl_cfg
  import ultl_pkg::*;
#(
  parameter int unsigned SECONDS_PER_MINUTE = SECONDS_PER_MINUTE_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [CFG_WIDTH-1:0]     cfg_wdata_i,
  output logic                     clear_o,
  output logic [MIN_WIDTH-1:0]     warn_minutes_o,
  output logic [COUNT_WIDTH-1:0]   warn_thr_o,
  output logic [COUNT_WIDTH-1:0]   lock_thr_o
);

  logic [MIN_WIDTH-1:0]   warn_min_q, warn_min_d;
  logic [MIN_WIDTH-1:0]   max_min_q, max_min_d;
  logic [MIN_WIDTH-1:0]   diff_min;
  logic [COUNT_WIDTH-1:0] diff_secs;
  logic                   warn_on;

  always_comb begin
    warn_min_d = warn_min_q;
    max_min_d  = max_min_q;
    clear_o    = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_WARN: begin
          warn_min_d = cfg_wdata_i;
          clear_o    = 1'b1;
        end
        CFG_IDX_MAX: begin
          max_min_d = cfg_wdata_i;
          clear_o   = 1'b1;
        end
        default: begin
          clear_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warn_min_q <= '0;
      max_min_q  <= '0;
    end else begin
      warn_min_q <= warn_min_d;
      max_min_q  <= max_min_d;
    end
  end

  // The warning sits warn_minutes ahead of the limit and is off when it would
  // fall at or before the start or when warn_minutes is zero.
  assign warn_on  = (warn_min_q != '0) && (max_min_q > warn_min_q);
  assign diff_min = max_min_q - warn_min_q;

  ultl_to_secs #(
    .SECONDS_PER_MINUTE(SECONDS_PER_MINUTE),
    .COUNT_WIDTH       (COUNT_WIDTH)
  ) u_warn_secs (
    .minutes_i(diff_min),
    .secs_o   (diff_secs)
  );

  ultl_to_secs #(
    .SECONDS_PER_MINUTE(SECONDS_PER_MINUTE),
    .COUNT_WIDTH       (COUNT_WIDTH)
  ) u_lock_secs (
    .minutes_i(max_min_q),
    .secs_o   (lock_thr_o)
  );

  assign warn_thr_o     = warn_on ? diff_secs : '0;
  assign warn_minutes_o = warn_min_q;

endmodule

// File: design/ultl_core.sv
module ultl_core
  import ultl_pkg::*;
#(
  parameter int unsigned SECONDS_PER_MINUTE = SECONDS_PER_MINUTE_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   clear_i,
  input  logic                   en_i,
  input  cmd_e                   cmd_i,
  input  logic                   segment_i,
  input  logic [MIN_WIDTH-1:0]   suspend_minutes_i,
  input  logic [MIN_WIDTH-1:0]   warn_minutes_i,
  input  logic [COUNT_WIDTH-1:0] warn_thr_i,
  input  logic [COUNT_WIDTH-1:0] lock_thr_i,
  output result_t                result_o
);

  localparam logic [COUNT_WIDTH-1:0] CntMax = {COUNT_WIDTH{1'b1}};

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == CntMax) ? CntMax : v + COUNT_WIDTH'(1);
  endfunction

  logic [COUNT_WIDTH-1:0] use_q, use_d;
  lock_e                  lock_q, lock_d;
  logic                   prev_seg_q, prev_seg_d;
  logic                   warned_q, warned_d;
  logic                   granted_q, granted_d;
  logic                   susp_active_q, susp_active_d;
  logic [COUNT_WIDTH-1:0] susp_left_q, susp_left_d;
  logic [COUNT_WIDTH-1:0] susp_total_q, susp_total_d;
  logic [COUNT_WIDTH-1:0] susp_warn_at_q, susp_warn_at_d;
  logic [COUNT_WIDTH-1:0] susp_elapsed_q, susp_elapsed_d;
  logic                   susp_warned_q, susp_warned_d;
  logic                   susp_fired_q, susp_fired_d;

  logic [MIN_WIDTH-1:0]   y_less_warn;
  logic [COUNT_WIDTH-1:0] y_secs;
  logic [COUNT_WIDTH-1:0] y_warn_secs;

  logic                   counting;
  logic                   go_on;
  logic [COUNT_WIDTH-1:0] use_base;
  logic [COUNT_WIDTH-1:0] use_next;
  logic                   warned_base;
  lock_e                  lock_cur;

  assign y_less_warn = suspend_minutes_i - warn_minutes_i;

  ultl_to_secs #(
    .SECONDS_PER_MINUTE(SECONDS_PER_MINUTE),
    .COUNT_WIDTH       (COUNT_WIDTH)
  ) u_y_secs (
    .minutes_i(suspend_minutes_i),
    .secs_o   (y_secs)
  );

  ultl_to_secs #(
    .SECONDS_PER_MINUTE(SECONDS_PER_MINUTE),
    .COUNT_WIDTH       (COUNT_WIDTH)
  ) u_y_warn_secs (
    .minutes_i(y_less_warn),
    .secs_o   (y_warn_secs)
  );

  always_comb begin
    use_d          = use_q;
    lock_d         = lock_q;
    prev_seg_d     = prev_seg_q;
    warned_d       = warned_q;
    granted_d      = granted_q;
    susp_active_d  = susp_active_q;
    susp_left_d    = susp_left_q;
    susp_total_d   = susp_total_q;
    susp_warn_at_d = susp_warn_at_q;
    susp_elapsed_d = susp_elapsed_q;
    susp_warned_d  = susp_warned_q;
    susp_fired_d   = susp_fired_q;
    result_o       = '{lock_state: LK_NONE, show_warning: 1'b0,
                       start_rest_lock: 1'b0, start_unavailable_lock: 1'b0};

    counting    = susp_active_q && (susp_left_q != '0);
    go_on       = 1'b1;
    use_base    = use_q;
    warned_base = warned_q;
    lock_cur    = lock_q;
    use_next    = '0;

    case (cmd_i)
      CMD_TICK: begin
        if (counting) begin
          susp_left_d    = susp_left_q - COUNT_WIDTH'(1);
          susp_elapsed_d = sat_inc(susp_elapsed_q);
        end
        if (segment_i) begin
          prev_seg_d = 1'b1;
          if (counting || granted_q) begin
            lock_d = LK_NONE;
          end else begin
            use_d    = '0;
            warned_d = 1'b0;
            if (lock_q != LK_UNAV) begin
              lock_d                          = LK_UNAV;
              result_o.start_unavailable_lock = 1'b1;
            end
          end
        end else if (lock_q == LK_REST) begin
          prev_seg_d = 1'b0;
        end else begin
          // Coming back from an unavailable segment starts a fresh session.
          if (prev_seg_q) begin
            use_base    = '0;
            warned_base = 1'b0;
            lock_cur    = LK_NONE;
            granted_d   = 1'b0;
          end
          prev_seg_d = 1'b0;
          use_d      = use_base;
          warned_d   = warned_base;
          lock_d     = lock_cur;

          if (susp_active_q) begin
            if (!susp_fired_q && (susp_total_q != '0) &&
                (susp_elapsed_d >= susp_total_q)) begin
              susp_fired_d             = 1'b1;
              lock_d                   = LK_REST;
              result_o.start_rest_lock = 1'b1;
              go_on                    = 1'b0;
            end else begin
              if (!susp_warned_q && (susp_warn_at_q != '0) &&
                  (susp_elapsed_d > susp_warn_at_q) &&
                  (susp_elapsed_d < susp_total_q)) begin
                susp_warned_d         = 1'b1;
                result_o.show_warning = 1'b1;
              end
              if (susp_left_d != '0) begin
                go_on = 1'b0;
              end else begin
                // Suspend ran out: drop it and count use from zero.
                susp_active_d  = 1'b0;
                susp_left_d    = '0;
                susp_total_d   = '0;
                susp_warn_at_d = '0;
                susp_elapsed_d = '0;
                susp_warned_d  = 1'b0;
                susp_fired_d   = 1'b0;
                use_base       = '0;
                warned_base    = 1'b0;
              end
            end
          end

          if (go_on) begin
            use_next = sat_inc(use_base);
            use_d    = use_next;
            warned_d = warned_base;
            if (lock_cur == LK_NONE) begin
              if (!warned_base && (warn_thr_i != '0) && (use_next >= warn_thr_i)) begin
                warned_d              = 1'b1;
                result_o.show_warning = 1'b1;
              end
              if ((lock_thr_i != '0) && (use_next >= lock_thr_i)) begin
                lock_d                   = LK_REST;
                result_o.start_rest_lock = 1'b1;
              end
            end
          end
        end
      end
      CMD_REST_DONE: begin
        lock_d         = LK_NONE;
        use_d          = '0;
        warned_d       = 1'b0;
        susp_active_d  = 1'b0;
        susp_left_d    = '0;
        susp_total_d   = '0;
        susp_warn_at_d = '0;
        susp_elapsed_d = '0;
        susp_warned_d  = 1'b0;
        susp_fired_d   = 1'b0;
        prev_seg_d     = 1'b0;
      end
      CMD_PARENT: begin
        lock_d    = LK_NONE;
        granted_d = 1'b1;
      end
      CMD_SUSPEND: begin
        if (suspend_minutes_i == '0) begin
          susp_active_d  = 1'b0;
          susp_left_d    = '0;
          susp_total_d   = '0;
          susp_warn_at_d = '0;
          susp_elapsed_d = '0;
          susp_warned_d  = 1'b0;
          susp_fired_d   = 1'b0;
        end else begin
          susp_active_d  = 1'b1;
          susp_total_d   = y_secs;
          susp_left_d    = y_secs;
          susp_elapsed_d = '0;
          susp_fired_d   = 1'b0;
          susp_warned_d  = 1'b0;
          if (!segment_i && (warn_minutes_i != '0) && (suspend_minutes_i > warn_minutes_i)) begin
            susp_warn_at_d = y_warn_secs;
          end else begin
            susp_warn_at_d = '0;
          end
          use_d    = '0;
          warned_d = 1'b0;
        end
      end
      default: begin
        lock_d = lock_q;
      end
    endcase

    result_o.lock_state = lock_d;

    // A register write resets the session; the parent grant survives it.
    if (clear_i) begin
      use_d          = '0;
      warned_d       = 1'b0;
      lock_d         = LK_NONE;
      prev_seg_d     = 1'b0;
      granted_d      = granted_q;
      susp_active_d  = 1'b0;
      susp_left_d    = '0;
      susp_total_d   = '0;
      susp_warn_at_d = '0;
      susp_elapsed_d = '0;
      susp_warned_d  = 1'b0;
      susp_fired_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_q          <= '0;
      lock_q         <= LK_NONE;
      prev_seg_q     <= 1'b0;
      warned_q       <= 1'b0;
      granted_q      <= 1'b0;
      susp_active_q  <= 1'b0;
      susp_left_q    <= '0;
      susp_total_q   <= '0;
      susp_warn_at_q <= '0;
      susp_elapsed_q <= '0;
      susp_warned_q  <= 1'b0;
      susp_fired_q   <= 1'b0;
    end else if (en_i || clear_i) begin
      use_q          <= use_d;
      lock_q         <= lock_d;
      prev_seg_q     <= prev_seg_d;
      warned_q       <= warned_d;
      granted_q      <= granted_d;
      susp_active_q  <= susp_active_d;
      susp_left_q    <= susp_left_d;
      susp_total_q   <= susp_total_d;
      susp_warn_at_q <= susp_warn_at_d;
      susp_elapsed_q <= susp_elapsed_d;
      susp_warned_q  <= susp_warned_d;
      susp_fired_q   <= susp_fired_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    susp_active_q |-> (susp_left_q <= susp_total_q))
    else $error("suspend countdown exceeds its total");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !susp_active_q |-> (susp_total_q == '0) && (susp_elapsed_q == '0))
    else $error("idle suspend holds stale counts");

endmodule

// File: design/usage_time_limit_timer_unit.sv
// Continuous-use limiter. Each input word is one event (second tick with its
// segment, rest lock finished, parent dismissal, or start of a suspend) and
// yields exactly one result word with the lock after the event and three
// one-shot flags. An accepted word lands in an input register, is applied to
// the state once the result register is free or being drained, and its result
// is registered; one word per cycle is sustained while the output is not
// stalled. Writing either register clears the use count, warning, suspend and
// lock (a parent grant is kept); write only while no event is in flight.
module usage_time_limit_timer_unit
  import ultl_pkg::*;
#(
  parameter int unsigned SECONDS_PER_MINUTE = SECONDS_PER_MINUTE_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [CFG_WIDTH-1:0]     cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               cmd_i,
  input  logic                     segment_i,
  input  logic [MIN_WIDTH-1:0]     suspend_minutes_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               lock_state_o,
  output logic                     show_warning_o,
  output logic                     start_rest_lock_o,
  output logic                     start_unavailable_lock_o
);

  logic                   in_valid_q, in_valid_d;
  cmd_e                   cmd_q;
  logic                   segment_q;
  logic [MIN_WIDTH-1:0]   susp_min_q;
  logic                   out_valid_q, out_valid_d;
  result_t                res_q;
  result_t                res;
  logic                   in_take;
  logic                   proc;
  logic                   cfg_clear;
  logic [MIN_WIDTH-1:0]   warn_minutes;
  logic [COUNT_WIDTH-1:0] warn_thr;
  logic [COUNT_WIDTH-1:0] lock_thr;

  // The held word moves on once the result register is free or being drained.
  assign proc       = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && !proc;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (proc) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (proc) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q      <= cmd_e'(cmd_i);
      segment_q  <= segment_i;
      susp_min_q <= suspend_minutes_i;
    end
    if (proc) begin
      res_q <= res;
    end
  end

  ultl_cfg #(
    .SECONDS_PER_MINUTE(SECONDS_PER_MINUTE),
    .COUNT_WIDTH       (COUNT_WIDTH)
  ) u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .clear_o       (cfg_clear),
    .warn_minutes_o(warn_minutes),
    .warn_thr_o    (warn_thr),
    .lock_thr_o    (lock_thr)
  );

  ultl_core #(
    .SECONDS_PER_MINUTE(SECONDS_PER_MINUTE),
    .COUNT_WIDTH       (COUNT_WIDTH)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .clear_i          (cfg_clear),
    .en_i             (proc),
    .cmd_i            (cmd_q),
    .segment_i        (segment_q),
    .suspend_minutes_i(susp_min_q),
    .warn_minutes_i   (warn_minutes),
    .warn_thr_i       (warn_thr),
    .lock_thr_i       (lock_thr),
    .result_o         (res)
  );

  assign out_valid_o              = out_valid_q;
  assign lock_state_o             = res_q.lock_state;
  assign show_warning_o           = res_q.show_warning;
  assign start_rest_lock_o        = res_q.start_rest_lock;
  assign start_unavailable_lock_o = res_q.start_unavailable_lock;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && start_rest_lock_o |-> lock_state_o == LK_REST)
    else $error("rest lock flagged without rest lock state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && start_unavailable_lock_o |-> lock_state_o == LK_UNAV)
    else $error("unavailable lock flagged without unavailable state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !proc |=> in_valid_q)
    else $error("held event dropped without being applied");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> out_valid_q)
    else $error("applied event produced no result");

endmodule
